// ===== hdl/lcdst_pkg.sv =====
// shared types and constants for the lcd scan timing generator
package lcdst_pkg;

  localparam int DOT_W  = 9;
  localparam int LINE_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam int DEF_CYCLES_PER_DOT  = 4;
  localparam int DEF_DOTS_PER_LINE   = 308;
  localparam int DEF_VISIBLE_DOTS    = 240;
  localparam int DEF_LINES_PER_FRAME = 228;
  localparam int DEF_VISIBLE_LINES   = 160;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HBLANK_IRQ_EN = 3'd0,
    REG_VBLANK_IRQ_EN = 3'd1,
    REG_VCOUNT_IRQ_EN = 3'd2,
    REG_VCOUNT_TARGET = 3'd3,
    REG_FORCED_BLANK  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              hblank_irq_enable;
    logic              vblank_irq_enable;
    logic              vcount_irq_enable;
    logic [LINE_W-1:0] vcount_target;
    logic              forced_blank;
  } cfg_t;

endpackage

// ===== hdl/lcd_scan_timing_generator_top.sv =====
// lcd scan timing generator: prescaler, dot and line counters, result register
// latency: the result of every accepted transaction, tick or not, is valid the cycle after it is accepted
// throughput: one transaction per cycle while in_stall is low, set by the single counter update stage
// the input stalls only while a result is held in the output register and stalled
// synchronous reset clears prescaler, counters, configuration and output valid
module lcd_scan_timing_generator_top #(
  parameter int CYCLES_PER_DOT  = lcdst_pkg::DEF_CYCLES_PER_DOT,
  parameter int DOTS_PER_LINE   = lcdst_pkg::DEF_DOTS_PER_LINE,
  parameter int VISIBLE_DOTS    = lcdst_pkg::DEF_VISIBLE_DOTS,
  parameter int LINES_PER_FRAME = lcdst_pkg::DEF_LINES_PER_FRAME,
  parameter int VISIBLE_LINES   = lcdst_pkg::DEF_VISIBLE_LINES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdst_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdst_pkg::DATA_W-1:0] pwdata,
  output logic [lcdst_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         tick_valid,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcdst_pkg::DOT_W-1:0]  dot_position,
  output logic [lcdst_pkg::LINE_W-1:0] line_position,
  output logic                         hblank_flag,
  output logic                         vblank_flag,
  output logic                         vcount_flag,
  output logic                         hblank_irq,
  output logic                         vblank_irq,
  output logic                         vcount_irq,
  output logic                         frame_done
);
  import lcdst_pkg::*;

  localparam int PRE_W = (CYCLES_PER_DOT > 1) ? $clog2(CYCLES_PER_DOT) : 1;

  cfg_t cfg;

  logic [PRE_W-1:0]  prescale_count, prescale_count_next;
  logic [DOT_W-1:0]  dot_counter, dot_counter_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;
  logic              accept, count, advance;
  logic              h_irq, v_irq, c_irq, done;

  lcdst_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign count    = accept && tick_valid;
  assign advance  = count && (prescale_count == PRE_W'(CYCLES_PER_DOT - 1));

  always_comb begin
    prescale_count_next = prescale_count;
    dot_counter_next    = dot_counter;
    line_counter_next   = line_counter;
    if (count) begin
      if (advance) begin
        prescale_count_next = '0;
      end else begin
        prescale_count_next = prescale_count + PRE_W'(1);
      end
    end
    if (advance) begin
      if (dot_counter == DOT_W'(DOTS_PER_LINE - 1)) begin
        dot_counter_next = '0;
        if (line_counter == LINE_W'(LINES_PER_FRAME - 1)) begin
          line_counter_next = '0;
        end else begin
          line_counter_next = line_counter + LINE_W'(1);
        end
      end else begin
        dot_counter_next = dot_counter + DOT_W'(1);
      end
    end
    done  = advance && !cfg.forced_blank &&
            (dot_counter == DOT_W'(VISIBLE_DOTS - 1)) &&
            (line_counter == LINE_W'(VISIBLE_LINES - 1));
    h_irq = advance && cfg.hblank_irq_enable &&
            (dot_counter_next == DOT_W'(VISIBLE_DOTS));
    v_irq = advance && cfg.vblank_irq_enable && (dot_counter_next == '0) &&
            (line_counter_next == LINE_W'(VISIBLE_LINES));
    c_irq = advance && cfg.vcount_irq_enable && (dot_counter_next == '0) &&
            (line_counter_next == cfg.vcount_target);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      dot_counter    <= '0;
      line_counter   <= '0;
      out_valid      <= 1'b0;
    end else begin
      prescale_count <= prescale_count_next;
      dot_counter    <= dot_counter_next;
      line_counter   <= line_counter_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dot_position  <= dot_counter_next;
      line_position <= line_counter_next;
      hblank_flag   <= (dot_counter_next >= DOT_W'(VISIBLE_DOTS));
      vblank_flag   <= (line_counter_next >= LINE_W'(VISIBLE_LINES));
      vcount_flag   <= (line_counter_next == cfg.vcount_target);
      hblank_irq    <= h_irq;
      vblank_irq    <= v_irq;
      vcount_irq    <= c_irq;
      frame_done    <= done;
    end
  end

endmodule

// ===== hdl/lcdst_regs.sv =====
// configuration register file behind the apb-style port
module lcdst_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdst_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdst_pkg::DATA_W-1:0] pwdata,
  output logic [lcdst_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output lcdst_pkg::cfg_t              cfg
);
  import lcdst_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_HBLANK_IRQ_EN: cfg.hblank_irq_enable <= pwdata[0];
        REG_VBLANK_IRQ_EN: cfg.vblank_irq_enable <= pwdata[0];
        REG_VCOUNT_IRQ_EN: cfg.vcount_irq_enable <= pwdata[0];
        REG_VCOUNT_TARGET: cfg.vcount_target     <= pwdata[LINE_W-1:0];
        REG_FORCED_BLANK:  cfg.forced_blank      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_HBLANK_IRQ_EN: prdata[0] = cfg.hblank_irq_enable;
      REG_VBLANK_IRQ_EN: prdata[0] = cfg.vblank_irq_enable;
      REG_VCOUNT_IRQ_EN: prdata[0] = cfg.vcount_irq_enable;
      REG_VCOUNT_TARGET: prdata[LINE_W-1:0] = cfg.vcount_target;
      REG_FORCED_BLANK:  prdata[0] = cfg.forced_blank;
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lcdst_checker.sv =====
// port-level checks for the lcd scan timing generator and their bind
module lcdst_checker #(
  parameter int VISIBLE_DOTS  = lcdst_pkg::DEF_VISIBLE_DOTS,
  parameter int VISIBLE_LINES = lcdst_pkg::DEF_VISIBLE_LINES
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lcdst_pkg::DOT_W-1:0]  dot_position,
  input logic [lcdst_pkg::LINE_W-1:0] line_position,
  input logic                         hblank_flag,
  input logic                         vcount_flag,
  input logic                         hblank_irq,
  input logic                         vblank_irq,
  input logic                         vcount_irq,
  input logic                         frame_done
);
  import lcdst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dot_position))
    else $error("stalled result transaction was dropped or changed");

  a_hblank_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && hblank_irq |-> hblank_flag &&
      dot_position == DOT_W'(VISIBLE_DOTS))
    else $error("hblank interrupt away from first blank dot");

  a_vblank_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> dot_position == '0 &&
      line_position == LINE_W'(VISIBLE_LINES))
    else $error("vblank interrupt away from first blank line");

  a_vcount_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && vcount_irq |-> vcount_flag && dot_position == '0)
    else $error("vcount interrupt without line match at dot zero");

  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> dot_position == DOT_W'(VISIBLE_DOTS) &&
      line_position == LINE_W'(VISIBLE_LINES - 1))
    else $error("frame done away from end of last visible dot");

endmodule

bind lcd_scan_timing_generator_top lcdst_checker #(
  .VISIBLE_DOTS  (VISIBLE_DOTS),
  .VISIBLE_LINES (VISIBLE_LINES)
) u_lcdst_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .dot_position  (dot_position),
  .line_position (line_position),
  .hblank_flag   (hblank_flag),
  .vcount_flag   (vcount_flag),
  .hblank_irq    (hblank_irq),
  .vblank_irq    (vblank_irq),
  .vcount_irq    (vcount_irq),
  .frame_done    (frame_done)
);
